/* hdl/sdtq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted deadline timer queue package
// Shared types, command codes, status codes and cell operations.
// ----------------------------------------------------------------------------
package sdtq_pkg;

	localparam logic [1:0] CMD_SCHEDULE = 2'd0;
	localparam logic [1:0] CMD_CANCEL   = 2'd1;
	localparam logic [1:0] CMD_POLL     = 2'd2;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_INVALID = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EVENT  = 1'b1;

	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_POP    = 2'd3;

	localparam logic [19:0] NS_PER_MS = 20'd1000000;
	localparam logic [63:0] MS_LIMIT  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000000;

	typedef struct packed {
		logic        valid;
		logic [63:0] deadline;
		logic [7:0]  handler;
		logic [15:0] argument;
	} slot_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] key;
		logic [7:0]  handler;
		logic [15:0] argument;
	} cell_ctl_t;

endpackage

/* hdl/sdtq_cell.sv */
// ----------------------------------------------------------------------------
// Timer queue cell
// One queue slot: holds, takes the new timer, or takes a neighbour's timer.
// ----------------------------------------------------------------------------
module sdtq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sdtq_pkg::cell_ctl_t ctl,
	input  sdtq_pkg::slot_t    prev_slot,
	input  sdtq_pkg::slot_t    next_slot,
	input  logic               prev_le,
	input  logic               hit_in,
	output sdtq_pkg::slot_t    slot,
	output logic               le,
	output logic               hit_out
);
	import sdtq_pkg::*;

	logic        valid_q;
	logic [63:0] deadline_q;
	logic [7:0]  handler_q;
	logic [15:0] argument_q;
	logic        match;
	slot_t       slot_d;

	assign slot    = '{valid: valid_q, deadline: deadline_q, handler: handler_q,
		argument: argument_q};
	assign le      = valid_q & (deadline_q <= ctl.key);
	assign match   = valid_q & (handler_q == ctl.handler) & (argument_q == ctl.argument);
	assign hit_out = hit_in | match;

	always_comb begin
		slot_d = slot;
		unique case (ctl.op)
			OP_INSERT: begin
				if (!le) begin
					if (prev_le) begin
						slot_d = '{valid: 1'b1, deadline: ctl.key, handler: ctl.handler,
							argument: ctl.argument};
					end else begin
						slot_d = prev_slot;
					end
				end
			end
			OP_REMOVE: begin
				if (hit_out) begin
					slot_d = next_slot;
				end
			end
			OP_POP: begin
				slot_d = next_slot;
			end
			default: begin
				slot_d = slot;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		deadline_q <= slot_d.deadline;
		handler_q  <= slot_d.handler;
		argument_q <= slot_d.argument;
	end

endmodule

/* hdl/sorted_deadline_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// Sorted deadline timer queue
// Keeps up to QUEUE_DEPTH timers in a row of cells, sorted by deadline in
// nanoseconds, equal deadlines in arrival order. Schedule forms the low and
// high 32 x 20 bit partial products for the millisecond to nanosecond
// scaling, one saturating sum and one saturating add of the current time, then
// every cell shifts or takes the new timer at once when the output register
// is free. Cancel removes one matching timer per cycle from the first match
// onwards, then emits the count item. Poll pops one due timer from the head
// per cycle while the output register is free, emitting one event item
// each, then the count item. A new item is taken only when the previous one
// has delivered its final result and the output register is free.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [151:0] s_tdata,  // now_time, delay in ms, handler, argument
	input  logic [1:0]   s_tuser,  // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // status, count, fired_handler, fired_argument
	output logic         m_tuser,  // kind
	output logic         m_tlast
);
	import sdtq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL_LO = 3'd1;
	localparam logic [2:0] ST_MUL_HI = 3'd2;
	localparam logic [2:0] ST_SUM    = 3'd3;
	localparam logic [2:0] ST_DUE    = 3'd4;
	localparam logic [2:0] ST_INSERT = 3'd5;
	localparam logic [2:0] ST_CANCEL = 3'd6;
	localparam logic [2:0] ST_POLL   = 3'd7;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW+4:0] cnt_ext;
	logic          m_tvalid_q;

	logic [63:0] now_q, delay_q, ns_q, due_q;
	logic [7:0]  handler_q;
	logic [15:0] argument_q;
	logic [51:0] prod_lo_q;
	logic [31:0] prod_hi_q;
	logic [64:0] due_sum;

	logic        kind_q, last_q;
	logic [1:0]  status_q;
	logic [4:0]  count_q;
	logic [7:0]  fh_q;
	logic [15:0] fa_q;

	logic        out_load, out_kind_d, out_last_d;
	logic [1:0]  out_status_d;
	logic [4:0]  out_count_d;
	logic [7:0]  out_h_d;
	logic [15:0] out_a_d;

	logic      accept, out_free, full, hit_any, head_due;
	cell_ctl_t ctl;

	slot_t slots     [QUEUE_DEPTH];
	slot_t prev_slots[QUEUE_DEPTH];
	slot_t next_slots[QUEUE_DEPTH];
	logic  les       [QUEUE_DEPTH];
	logic  prev_les  [QUEUE_DEPTH];
	logic  hits      [QUEUE_DEPTH];
	logic  prev_hits [QUEUE_DEPTH];

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_head
				assign prev_slots[i] = '0;
				assign prev_les[i]   = 1'b1;
				assign prev_hits[i]  = 1'b0;
			end else begin : g_body
				assign prev_slots[i] = slots[i-1];
				assign prev_les[i]   = les[i-1];
				assign prev_hits[i]  = hits[i-1];
			end
			if (i == QUEUE_DEPTH - 1) begin : g_tail
				assign next_slots[i] = '0;
			end else begin : g_inner
				assign next_slots[i] = slots[i+1];
			end
			sdtq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.prev_slot(prev_slots[i]),
				.next_slot(next_slots[i]),
				.prev_le  (prev_les[i]),
				.hit_in   (prev_hits[i]),
				.slot     (slots[i]),
				.le       (les[i]),
				.hit_out  (hits[i])
			);
		end
	endgenerate

	assign full     = slots[QUEUE_DEPTH-1].valid;
	assign hit_any  = hits[QUEUE_DEPTH-1];
	assign head_due = slots[0].valid & (slots[0].deadline <= now_q);

	assign out_free = !m_tvalid_q | m_tready;
	assign s_tready = (state_q == ST_IDLE) & out_free;
	assign accept   = s_tvalid & s_tready;
	assign cnt_ext  = {5'b0, cnt_q};
	assign due_sum  = {1'b0, now_q} + {1'b0, ns_q};

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		out_load     = 1'b0;
		out_kind_d   = KIND_STATUS;
		out_status_d = STS_OK;
		out_count_d  = 5'd0;
		out_h_d      = 8'd0;
		out_a_d      = 16'd0;
		out_last_d   = 1'b1;
		ctl.op       = OP_HOLD;
		ctl.key      = due_q;
		ctl.handler  = handler_q;
		ctl.argument = argument_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_d = '0;
					case (s_tuser)
						CMD_SCHEDULE: begin
							if (s_tdata[135:128] == 8'd0) begin
								out_load     = 1'b1;
								out_status_d = STS_INVALID;
							end else if (full) begin
								out_load     = 1'b1;
								out_status_d = STS_FULL;
							end else begin
								state_d = ST_MUL_LO;
							end
						end
						CMD_CANCEL: begin
							if (s_tdata[135:128] == 8'd0) begin
								out_load = 1'b1;
							end else begin
								state_d = ST_CANCEL;
							end
						end
						CMD_POLL: begin
							state_d = ST_POLL;
						end
						default: begin
							out_load     = 1'b1;
							out_status_d = STS_INVALID;
						end
					endcase
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SUM;
			ST_SUM:    state_d = ST_DUE;
			ST_DUE:    state_d = ST_INSERT;
			ST_INSERT: begin
				if (out_free) begin
					ctl.op   = OP_INSERT;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CANCEL: begin
				if (hit_any) begin
					ctl.op = OP_REMOVE;
					cnt_d  = cnt_q + CW'(1);
				end else if (out_free) begin
					out_load    = 1'b1;
					out_count_d = cnt_ext[4:0];
					state_d     = ST_IDLE;
				end
			end
			ST_POLL: begin
				if (out_free) begin
					out_load = 1'b1;
					if (head_due) begin
						ctl.op     = OP_POP;
						cnt_d      = cnt_q + CW'(1);
						out_kind_d = KIND_EVENT;
						out_h_d    = slots[0].handler;
						out_a_d    = slots[0].argument;
						out_last_d = 1'b0;
					end else begin
						out_count_d = cnt_ext[4:0];
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q      <= s_tdata[63:0];
			delay_q    <= s_tdata[127:64];
			handler_q  <= s_tdata[135:128];
			argument_q <= s_tdata[151:136];
		end
		if (state_q == ST_MUL_LO) begin
			prod_lo_q <= 52'(delay_q[31:0]) * 52'(NS_PER_MS);
		end
		if (state_q == ST_MUL_HI) begin
			prod_hi_q <= 32'(52'(delay_q[63:32]) * 52'(NS_PER_MS));
		end
		if (state_q == ST_SUM) begin
			ns_q <= (delay_q > MS_LIMIT) ? '1 : ({12'b0, prod_lo_q} + {prod_hi_q, 32'b0});
		end
		if (state_q == ST_DUE) begin
			due_q <= due_sum[64] ? '1 : due_sum[63:0];
		end
		if (out_load) begin
			kind_q   <= out_kind_d;
			status_q <= out_status_d;
			count_q  <= out_count_d;
			fh_q     <= out_h_d;
			fa_q     <= out_a_d;
			last_q   <= out_last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, fa_q, fh_q, count_q, status_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

/* verif/tb_sorted_deadline_timer_queue_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted deadline timer queue testbench
// Drives schedule, cancel and poll items into the timer queue over the input
// stream and checks every output item against a local model of the sorted
// queue. A directed opening covers null handlers, unknown commands,
// saturation, equal deadlines, a full queue and a poll that drains all
// sixteen entries. A random section follows: mostly timelines that advance
// steadily, with some raw noise mixed in. Both sides insert random stalls.
// ----------------------------------------------------------------------------
module tb_sorted_deadline_timer_queue_top;
	import sdtq_pkg::*;

	localparam int          QDEPTH      = 16;
	localparam logic [1:0]  CMD_BAD     = 2'd3;
	localparam logic [63:0] SAT_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MS_TO_NS    = 64'd1000000;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          LONG_HOLD   = 150;
	localparam int          TAIL_ITEMS  = 30;

	typedef struct {
		logic [1:0]  command;
		logic [63:0] now_ns;
		logic [63:0] wait_ms;
		logic [7:0]  handler;
		logic [15:0] argument;
		bit          drain;
	} timer_cmd_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [4:0]  count;
		logic [7:0]  handler;
		logic [15:0] argument;
		logic        is_last;
	} timer_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;   // now_time, delay in ms, handler, argument
	logic [1:0]   s_tuser = '0;   // command
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;        // status, count, fired_handler, fired_argument
	logic         m_tuser;        // kind
	logic         m_tlast;

	timer_cmd_t    cmd_q[$];
	timer_result_t result_q[$];

	logic [63:0] due_at[QDEPTH];
	logic [7:0]  slot_handler[QDEPTH];
	logic [15:0] slot_argument[QDEPTH];
	int          occupancy = 0;

	int  n_total = 0;
	int  n_taken = 0;
	int  n_errors = 0;
	int  n_cycles = 0;
	int  n_sched_ok = 0;
	int  n_full = 0;
	int  n_invalid = 0;
	int  n_cancelled = 0;
	int  n_fired = 0;
	int  src_gap = 0;
	int  snk_gap = 0;
	int  hold_left = 0;
	int  next_hold_at = 60;
	bit  item_taken = 1'b0;
	logic       nv;
	timer_cmd_t nxt;

	logic quiet;
	logic calm;
	assign quiet = (n_taken + TAIL_ITEMS >= n_total);
	assign calm  = quiet || ((n_taken / 20) % 3 == 2);

	sorted_deadline_timer_queue_top #(.QUEUE_DEPTH(QDEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		n_errors++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	task automatic add_cmd(input logic [1:0] command, input logic [63:0] now_ns,
		input logic [63:0] wait_ms, input logic [7:0] handler,
		input logic [15:0] argument, input bit drain);
		timer_cmd_t c;
		c.command  = command;
		c.now_ns   = now_ns;
		c.wait_ms  = wait_ms;
		c.handler  = handler;
		c.argument = argument;
		c.drain    = drain;
		cmd_q.push_back(c);
		n_total++;
	endtask

	function automatic void expect_result(input logic kind, input logic [1:0] status,
		input int count, input logic [7:0] handler, input logic [15:0] argument,
		input logic is_last);
		timer_result_t r;
		r.kind     = kind;
		r.status   = status;
		r.count    = count[4:0];
		r.handler  = handler;
		r.argument = argument;
		r.is_last  = is_last;
		result_q.push_back(r);
	endfunction

	function automatic void predict_timer_queue(input timer_cmd_t c);
		logic [64:0] sum;
		logic [63:0] span;
		logic [63:0] due;
		int          pos;
		int          kept;
		int          fired;
		case (c.command)
			CMD_SCHEDULE: begin
				if (c.handler == 8'd0) begin
					n_invalid++;
					expect_result(KIND_STATUS, STS_INVALID, 0, 8'd0, 16'd0, 1'b1);
				end else if (occupancy >= QDEPTH) begin
					n_full++;
					expect_result(KIND_STATUS, STS_FULL, 0, 8'd0, 16'd0, 1'b1);
				end else begin
					span = (c.wait_ms > SAT_MAX / MS_TO_NS) ? SAT_MAX : c.wait_ms * MS_TO_NS;
					sum  = {1'b0, c.now_ns} + {1'b0, span};
					due  = sum[64] ? SAT_MAX : sum[63:0];
					pos  = 0;
					while (pos < occupancy && due_at[pos] <= due)
						pos++;
					for (int i = occupancy; i > pos; i--) begin
						due_at[i]        = due_at[i - 1];
						slot_handler[i]  = slot_handler[i - 1];
						slot_argument[i] = slot_argument[i - 1];
					end
					due_at[pos]        = due;
					slot_handler[pos]  = c.handler;
					slot_argument[pos] = c.argument;
					occupancy++;
					n_sched_ok++;
					expect_result(KIND_STATUS, STS_OK, 0, 8'd0, 16'd0, 1'b1);
				end
			end
			CMD_CANCEL: begin
				kept = 0;
				if (c.handler != 8'd0) begin
					for (int i = 0; i < occupancy; i++) begin
						if (!(slot_handler[i] == c.handler && slot_argument[i] == c.argument)) begin
							due_at[kept]        = due_at[i];
							slot_handler[kept]  = slot_handler[i];
							slot_argument[kept] = slot_argument[i];
							kept++;
						end
					end
					n_cancelled += occupancy - kept;
					expect_result(KIND_STATUS, STS_OK, occupancy - kept, 8'd0, 16'd0, 1'b1);
					occupancy = kept;
				end else begin
					expect_result(KIND_STATUS, STS_OK, 0, 8'd0, 16'd0, 1'b1);
				end
			end
			CMD_POLL: begin
				fired = 0;
				while (fired < occupancy && due_at[fired] <= c.now_ns) begin
					expect_result(KIND_EVENT, STS_OK, 0, slot_handler[fired],
						slot_argument[fired], 1'b0);
					fired++;
				end
				for (int i = fired; i < occupancy; i++) begin
					due_at[i - fired]        = due_at[i];
					slot_handler[i - fired]  = slot_handler[i];
					slot_argument[i - fired] = slot_argument[i];
				end
				occupancy -= fired;
				n_fired   += fired;
				expect_result(KIND_STATUS, STS_OK, fired, 8'd0, 16'd0, 1'b1);
			end
			default: begin
				n_invalid++;
				expect_result(KIND_STATUS, STS_INVALID, 0, 8'd0, 16'd0, 1'b1);
			end
		endcase
	endfunction

	// accept input items and check output items
	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report_mismatch("output item with nothing pending",
						{30'd0, m_tlast, m_tuser, m_tdata}, 64'd0);
				end else begin
					want = result_q.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
					if (m_tdata[1:0] !== want.status)
						report_mismatch("status", 64'(m_tdata[1:0]), 64'(want.status));
					if (m_tdata[6:2] !== want.count)
						report_mismatch("count", 64'(m_tdata[6:2]), 64'(want.count));
					if (m_tdata[14:7] !== want.handler)
						report_mismatch("fired_handler", 64'(m_tdata[14:7]),
							64'(want.handler));
					if (m_tdata[30:15] !== want.argument)
						report_mismatch("fired_argument", 64'(m_tdata[30:15]),
							64'(want.argument));
					if (m_tlast !== want.is_last)
						report_mismatch("last", 64'(m_tlast), 64'(want.is_last));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_timer_queue(nxt);
				n_taken++;
				item_taken = 1'b1;
			end
		end
	end

	// source side
	always @(negedge clk) begin
		if (arst_n) begin
			nv = s_tvalid;
			if (item_taken) begin
				nv = 1'b0;
				item_taken = 1'b0;
			end
			if (!nv && cmd_q.size() != 0) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (!(cmd_q[0].drain && result_q.size() != 0)) begin
					if (!calm && $urandom_range(0, 4) == 0) begin
						src_gap = $urandom_range(0, 3);
					end else begin
						nxt = cmd_q.pop_front();
						nv  = 1'b1;
						s_tdata <= {nxt.argument, nxt.handler, nxt.wait_ms, nxt.now_ns};
						s_tuser <= nxt.command;
					end
				end
			end
			s_tvalid <= nv;
		end
	end

	// sink side
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!quiet && n_taken >= next_hold_at) begin
				hold_left = LONG_HOLD - 1;
				next_hold_at += 90;
				m_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				snk_gap = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d items taken, %0d results pending",
				n_cycles, n_taken, n_total, result_q.size());
			$display("** sorted_deadline_timer_queue_top: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [63:0] base_ns;
		logic [63:0] now_ns;
		logic [63:0] wait_ms;
		logic [7:0]  handler;
		logic [15:0] argument;
		logic [1:0]  command;
		int          pick;

		// directed opening
		add_cmd(CMD_POLL, 64'd0, 64'd0, 8'd0, 16'd0, 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd10, 64'd1, 8'd0, 16'h00AA, 1'b0);
		add_cmd(CMD_BAD, 64'd10, 64'd1, 8'd5, 16'h00AA, 1'b0);
		add_cmd(CMD_CANCEL, 64'd10, 64'd0, 8'd0, 16'd0, 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd100, 64'd0, 8'd7, 16'h1234, 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd100, 64'd0, 8'd7, 16'h1234, 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd50, 64'd0, 8'd7, 16'h1234, 1'b0);
		add_cmd(CMD_CANCEL, 64'd60, 64'd0, 8'd7, 16'h1234, 1'b0);
		add_cmd(CMD_SCHEDULE, SAT_MAX, SAT_MAX, 8'd255, 16'hFFFF, 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd0, SAT_MAX / MS_TO_NS + 64'd1, 8'd1, 16'h0000, 1'b0);
		add_cmd(CMD_SCHEDULE, SAT_MAX - 64'd5, 64'd1, 8'd2, 16'h0001, 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd5, 64'd0, 8'd3, 16'h0002, 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd5, 64'd0, 8'd4, 16'h0002, 1'b0);
		for (int i = 0; i < 11; i++)
			add_cmd(CMD_SCHEDULE, 64'd5, 64'd0, 8'(8 + i), 16'(16'h0100 + i), 1'b0);
		add_cmd(CMD_SCHEDULE, 64'd5, 64'd0, 8'd99, 16'h5555, 1'b0);
		add_cmd(CMD_POLL, 64'd4, 64'd0, 8'd0, 16'd0, 1'b0);
		add_cmd(CMD_POLL, SAT_MAX, 64'd0, 8'd0, 16'd0, 1'b0);

		// random section: timelines with steady time, plus noise
		base_ns = 64'd1000;
		for (int i = 0; i < 200; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 1) == 0)
					base_ns += 64'($urandom_range(0, 3)) * MS_TO_NS;
				else
					base_ns += 64'($urandom_range(0, 3000000));
				pick     = $urandom_range(0, 99);
				handler  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
					: 8'($urandom_range(1, 4));
				argument = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(0, 2));
				wait_ms  = 64'($urandom_range(0, 8));
				command  = (pick < 50) ? CMD_SCHEDULE : (pick < 65) ? CMD_CANCEL : CMD_POLL;
				add_cmd(command, base_ns, wait_ms, handler, argument, (i % 50) == 25);
			end else begin
				now_ns = {$urandom, $urandom};
				case ($urandom_range(0, 2))
					0: wait_ms = {$urandom, $urandom};
					1: wait_ms = 64'($urandom);
					default: wait_ms = 64'($urandom_range(0, 100));
				endcase
				add_cmd(2'($urandom_range(0, 3)), now_ns, wait_ms, 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)), (i % 50) == 25);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(n_taken == n_total && result_q.size() == 0))
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (result_q.size() != 0)
			report_mismatch("results left pending", 64'(result_q.size()), 64'd0);

		$display("%0d items: %0d timers scheduled, %0d refused as full, %0d invalid",
			n_taken, n_sched_ok, n_full, n_invalid);
		$display("%0d timers cancelled, %0d fired by polls, %0d mismatches",
			n_cancelled, n_fired, n_errors);
		if (n_errors == 0) begin
			$display("** sorted_deadline_timer_queue_top: PASSED **");
		end else begin
			$display("** sorted_deadline_timer_queue_top: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/sdtq_pkg.sv
hdl/sdtq_cell.sv
hdl/sorted_deadline_timer_queue_top.sv
verif/tb_sorted_deadline_timer_queue_top.sv
